// ===== rtl/cred_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cred_pkg
// Types and constants shared by the clipped-ReLU dot evaluator.
// ----------------------------------------------------------------------------
package cred_pkg;

  localparam int unsigned ACC_W     = 16;
  localparam int unsigned ACT_W     = 8;
  localparam int unsigned WGT_W     = 8;
  localparam int unsigned IDX_W     = 9;
  localparam int unsigned SUM_W     = 32;
  localparam int unsigned PROD_W    = ACT_W + WGT_W + 1;
  localparam int unsigned SCORE_W   = 12;

  localparam int unsigned ACC_SHIFT = 6;
  localparam int unsigned OUT_SHIFT = 5;

  localparam int SCORE_MAX = 2000;
  localparam int SCORE_MIN = -2000;

  // midgame scale 140/100, reduced to 7/5
  localparam int MG_NUM     = 140;
  localparam int MG_DEN     = 100;
  localparam int MG_GCD     = 20;
  localparam int MG_MUL     = MG_NUM / MG_GCD;
  localparam int MG_DIV     = MG_DEN / MG_GCD;
  localparam int MG_SRC_MAX = (SCORE_MAX * MG_DIV + MG_MUL - 1) / MG_MUL;

  localparam int unsigned RECIP_SHIFT = 16;
  localparam int unsigned RECIP       = (1 << RECIP_SHIFT) / MG_DIV;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_SCALE,
    ST_WAIT,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic mul_en;
    logic add_en;
    logic clear;
  } mac_ctrl_t;

  function automatic logic [ACT_W-1:0] clip_relu(input logic signed [ACC_W-1:0] a);
    logic [ACT_W-1:0] r;
    if (a[ACC_W-1]) begin
      r = '0;
    end else if (|a[ACC_W-2:ACC_SHIFT+ACT_W]) begin
      r = '1;
    end else begin
      r = a[ACC_SHIFT+ACT_W-1:ACC_SHIFT];
    end
    return r;
  endfunction

endpackage

// ===== rtl/cred_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cred_ram
// Generic RAM: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module cred_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end

endmodule

// ===== rtl/cred_mac.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cred_mac
// Two weight products and the running sum of the dot product.
// ----------------------------------------------------------------------------
module cred_mac
  import cred_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  mac_ctrl_t                ctrl_i,
  input  logic [ACT_W-1:0]         own_i,
  input  logic [ACT_W-1:0]         opp_i,
  input  logic signed [WGT_W-1:0]  w_own_i,
  input  logic signed [WGT_W-1:0]  w_opp_i,
  output logic [SUM_W-1:0]         sum_o
);

  logic signed [PROD_W-1:0] p_own_q, p_own_d;
  logic signed [PROD_W-1:0] p_opp_q, p_opp_d;
  logic [SUM_W-1:0]         sum_q, sum_d;

  always_comb begin
    p_own_d = $signed({1'b0, own_i}) * w_own_i;
    p_opp_d = $signed({1'b0, opp_i}) * w_opp_i;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      p_own_q <= p_own_d;
      p_opp_q <= p_opp_d;
    end
  end

  always_comb begin
    sum_d = sum_q;
    priority if (ctrl_i.clear) begin
      sum_d = '0;
    end else if (ctrl_i.add_en) begin
      sum_d = sum_q + SUM_W'(p_own_q) + SUM_W'(p_opp_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else begin
      sum_q <= sum_d;
    end
  end

  assign sum_o = sum_q;

endmodule

// ===== rtl/cred_scale.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cred_scale
// Bias, dequantising shift, 7/5 midgame scaling and clamping in three stages.
// ----------------------------------------------------------------------------
module cred_scale
  import cred_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [SUM_W-1:0]           sum_i,
  input  logic [SUM_W-1:0]           bias_i,
  input  logic                       kings_i,
  output logic                       done_o,
  output logic signed [SCORE_W-1:0]  mg_o,
  output logic signed [SCORE_W-1:0]  eg_o
);

  localparam int unsigned SW = SUM_W - OUT_SHIFT;
  localparam int unsigned PW = SCORE_W + 3;
  localparam int unsigned MW = PW - 1;
  localparam int unsigned RW = MW + RECIP_SHIFT - 2;

  localparam logic signed [SW-1:0] S_MAX  = SW'(SCORE_MAX);
  localparam logic signed [SW-1:0] S_MIN  = SW'(SCORE_MIN);
  localparam logic signed [SW-1:0] S_MGHI = SW'(MG_SRC_MAX);
  localparam logic signed [SW-1:0] S_MGLO = SW'(-MG_SRC_MAX);

  logic v1_q, v2_q, v3_q;

  logic [SUM_W-1:0]          total;
  logic signed [SW-1:0]      s;
  logic signed [SCORE_W-1:0] eg1_d, sc1_d;
  logic signed [SCORE_W-1:0] eg1_q, sc1_q;
  logic                      kings1_q;

  logic signed [PW-1:0]      p7;
  logic [MW-1:0]             m2_d;
  logic [RW-1:0]             prodr;
  logic [MW-1:0]             m2_q;
  logic [SCORE_W-1:0]        q0_q;
  logic                      neg2_q, kings2_q;
  logic signed [SCORE_W-1:0] eg2_q;

  logic [MW-1:0]             r;
  logic [SCORE_W-1:0]        q;
  logic signed [SCORE_W-1:0] mg3_d, eg3_d;

  always_comb begin
    total = sum_i + bias_i;
    s     = total[SUM_W-1:OUT_SHIFT];
    priority if (s > S_MAX) begin
      eg1_d = SCORE_W'(S_MAX);
    end else if (s < S_MIN) begin
      eg1_d = SCORE_W'(S_MIN);
    end else begin
      eg1_d = SCORE_W'(s);
    end
    priority if (s > S_MGHI) begin
      sc1_d = SCORE_W'(S_MGHI);
    end else if (s < S_MGLO) begin
      sc1_d = SCORE_W'(S_MGLO);
    end else begin
      sc1_d = SCORE_W'(s);
    end
  end

  always_comb begin
    p7    = $signed(PW'(sc1_q)) * $signed(PW'(MG_MUL));
    m2_d  = p7[PW-1] ? MW'(-p7) : MW'(p7);
    prodr = RW'(m2_d) * RW'(RECIP);
  end

  always_comb begin
    r     = m2_q - MW'(MW'(q0_q) * MW'(MG_DIV));
    q     = q0_q + SCORE_W'(r >= MW'(MG_DIV));
    mg3_d = neg2_q ? -$signed(q) : $signed(q);
    eg3_d = eg2_q;
    if (kings2_q) begin
      mg3_d = '0;
      eg3_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      eg1_q    <= eg1_d;
      sc1_q    <= sc1_d;
      kings1_q <= kings_i;
    end
    if (v1_q) begin
      m2_q     <= m2_d;
      q0_q     <= prodr[RECIP_SHIFT +: SCORE_W];
      neg2_q   <= p7[PW-1];
      kings2_q <= kings1_q;
      eg2_q    <= eg1_q;
    end
    if (v2_q) begin
      mg_o <= mg3_d;
      eg_o <= eg3_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= start_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  assign done_o = v3_q;

endmodule

// ===== rtl/clipped_relu_dot_evaluator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clipped_relu_dot_evaluator
// Clipped-ReLU output layer: weight memory, dot product and score scaling.
// ----------------------------------------------------------------------------
// Input words arrive on a valid/ready channel. A load word (func_i = 1)
// writes one weight into the weight RAM when its index is in range. An
// evaluation word reads two weights through the two RAM read ports,
// multiplies and, when its index is in range, adds into the running sum.
// The word flagged last runs on through the three-stage scale unit and
// produces one result word; the next input is taken once the result sits
// in the output register. Each word passes the RAM read, the product
// register and the sum register, one word at a time.
// The output register holds the result until out_ready_i; while it is full a
// further result waits in the scale unit, and input stops.
// Reset clears the running sum, the bias and all handshake state; the weight
// RAM is not cleared and must be loaded before use. cfg_we_i writes the
// output bias; users must write it only while the block is idle; unchecked.
// ----------------------------------------------------------------------------
module clipped_relu_dot_evaluator
  import cred_pkg::*;
#(
  parameter int unsigned HALF_WIDTH   = 256,
  parameter int unsigned HIDDEN_WIDTH = 512
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      func_i,
  input  logic [IDX_W-1:0]          index_i,
  input  logic signed [WGT_W-1:0]   weight_value_i,
  input  logic signed [ACC_W-1:0]   white_acc_i,
  input  logic signed [ACC_W-1:0]   black_acc_i,
  input  logic                      side_to_move_i,
  input  logic                      only_kings_i,
  input  logic                      last_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [SCORE_W-1:0] midgame_score_o,
  output logic signed [SCORE_W-1:0] endgame_score_o,
  input  logic                      cfg_we_i,
  input  logic signed [SUM_W-1:0]   cfg_wdata_i
);

  localparam int unsigned AW = $clog2(HIDDEN_WIDTH);

  state_e state_q, state_d;

  logic             accept;
  logic             load_ok, eval_ok;
  logic [ACT_W-1:0] white_clip, black_clip;
  logic [AW-1:0]    addr_a, addr_b;
  logic [WGT_W-1:0] w_a, w_b;

  logic [ACT_W-1:0] own_q, opp_q;
  logic             inrange_q, last_q, kings_q;
  logic [SUM_W-1:0] bias_q;
  logic [SUM_W-1:0] sum;

  mac_ctrl_t        mac_ctrl;
  logic             scale_start, scale_done;
  logic signed [SCORE_W-1:0] mg_res, eg_res;

  logic             out_valid_q, out_valid_d;
  logic             out_load;
  logic signed [SCORE_W-1:0] mg_q, eg_q;

  assign accept  = in_valid_i && in_ready_o;
  assign load_ok = 32'(index_i) < 32'(HIDDEN_WIDTH);
  assign eval_ok = (32'(index_i) < 32'(HALF_WIDTH)) &&
                   (32'(index_i) + 32'(HALF_WIDTH) < 32'(HIDDEN_WIDTH));
  assign addr_a  = AW'(index_i);
  assign addr_b  = AW'(32'(index_i) + 32'(HALF_WIDTH));

  assign white_clip = clip_relu(white_acc_i);
  assign black_clip = clip_relu(black_acc_i);

  cred_ram #(
    .WIDTH (WGT_W),
    .DEPTH (HIDDEN_WIDTH)
  ) u_wram (
    .clk_i     (clk_i),
    .we_i      (accept && func_i && load_ok),
    .waddr_i   (addr_a),
    .wdata_i   (weight_value_i),
    .re_i      (accept && !func_i),
    .raddr_a_i (addr_a),
    .raddr_b_i (addr_b),
    .rdata_a_o (w_a),
    .rdata_b_o (w_b)
  );

  always_ff @(posedge clk_i) begin
    if (accept && !func_i) begin
      own_q     <= side_to_move_i ? black_clip : white_clip;
      opp_q     <= side_to_move_i ? white_clip : black_clip;
      inrange_q <= eval_ok;
      last_q    <= last_i;
      kings_q   <= only_kings_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bias_q <= '0;
    end else if (cfg_we_i) begin
      bias_q <= cfg_wdata_i;
    end
  end

  cred_mac u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (mac_ctrl),
    .own_i   (own_q),
    .opp_i   (opp_q),
    .w_own_i ($signed(w_a)),
    .w_opp_i ($signed(w_b)),
    .sum_o   (sum)
  );

  cred_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (scale_start),
    .sum_i   (sum),
    .bias_i  (bias_q),
    .kings_i (kings_q),
    .done_o  (scale_done),
    .mg_o    (mg_res),
    .eg_o    (eg_res)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (accept && !func_i) state_d = ST_MUL;
      ST_MUL:   state_d = ST_ACC;
      ST_ACC:   state_d = last_q ? ST_SCALE : ST_IDLE;
      ST_SCALE: state_d = ST_WAIT;
      ST_WAIT:  if (scale_done) state_d = ST_OUT;
      ST_OUT:   if (out_load) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o      = 1'b0;
    mac_ctrl.mul_en = 1'b0;
    mac_ctrl.add_en = 1'b0;
    mac_ctrl.clear  = 1'b0;
    scale_start     = 1'b0;
    out_load        = 1'b0;
    unique case (state_q)
      ST_IDLE:  in_ready_o = 1'b1;
      ST_MUL:   mac_ctrl.mul_en = 1'b1;
      ST_ACC:   mac_ctrl.add_en = inrange_q;
      ST_SCALE: begin
        scale_start    = 1'b1;
        mac_ctrl.clear = 1'b1;
      end
      ST_WAIT:  ;
      ST_OUT:   out_load = !out_valid_q || out_ready_i;
      default:  ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    priority if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      mg_q <= mg_res;
      eg_q <= eg_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign midgame_score_o = mg_q;
  assign endgame_score_o = eg_q;

endmodule
